### src/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and character functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64_pkg;

	// Configuration register indexes
	localparam int unsigned REG_DIRECTION = 0;

	// Direction codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Results that one input transaction can cause at most
	localparam int unsigned MAX_RES = 5;
	localparam int unsigned RES_CNT_W = 3;
	localparam int unsigned RES_IDX_W = 3;

	// Default depth of the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_PAD = 8'h3D;  // '='
	localparam logic [7:0] CH_NL  = 8'h0A;  // newline

	// Character classes beyond the 64 sextet values
	localparam logic [6:0] CLS_PAD = 7'd64;
	localparam logic [6:0] CLS_WS  = 7'd65;
	localparam logic [6:0] CLS_BAD = 7'd66;

	typedef struct packed {
		logic       vld;
		logic [7:0] data;
		logic       bad;
	} res_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0] cnt;   // number of results, 1 to MAX_RES
		logic                 last;  // transaction ended the stream
		res_t [MAX_RES-1:0]   res;
	} cmd_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26)
			c = 8'h41 + {2'b00, s};
		else if (s < 6'd52)
			c = 8'h61 + {2'b00, s} - 8'd26;
		else if (s < 6'd62)
			c = 8'h30 + {2'b00, s} - 8'd52;
		else if (s == 6'd62)
			c = 8'h2B;
		else
			c = 8'h2F;
		return c;
	endfunction

	function automatic logic [6:0] classify(input logic [7:0] c);
		logic [6:0] v;
		if (c >= 8'h41 && c <= 8'h5A)
			v = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)
			v = 7'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			v = 7'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B)
			v = 7'd62;
		else if (c == 8'h2F)
			v = 7'd63;
		else if (c == CH_PAD)
			v = CLS_PAD;
		else if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A)
			v = CLS_WS;
		else
			v = CLS_BAD;
		return v;
	endfunction

endpackage

### src/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// Accepts stream transactions, keeps the group state and turns each
// transaction that causes results into one command listing all of them.
// ----------------------------------------------------------------------------
module b64_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          direction,
	input  logic          clear,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_data,
	input  logic          in_flag,
	input  logic          in_end,
	input  logic          q_full,
	output logic          q_push,
	output b64_pkg::cmd_t q_cmd
);

	logic [17:0] acc_q, acc_d;
	logic [1:0]  gc_q, gc_d;
	logic        pad_q, pad_d;
	logic [6:0]  cls;
	logic [23:0] grp;
	logic [b64_pkg::RES_CNT_W-1:0] n;
	b64_pkg::res_t [b64_pkg::MAX_RES-1:0] res;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		res   = '0;
		n     = '0;
		acc_d = acc_q;
		gc_d  = gc_q;
		pad_d = pad_q;
		cls   = b64_pkg::classify(in_data);
		grp   = '0;
		if (direction == b64_pkg::DIR_ENCODE) begin
			if (in_flag) begin
				if (gc_q == 2'd2) begin
					grp    = {acc_q[15:0], in_data};
					res[0] = '{vld: 1'b1, data: b64_pkg::sextet_char(grp[23:18]), bad: 1'b0};
					res[1] = '{vld: 1'b1, data: b64_pkg::sextet_char(grp[17:12]), bad: 1'b0};
					res[2] = '{vld: 1'b1, data: b64_pkg::sextet_char(grp[11:6]), bad: 1'b0};
					res[3] = '{vld: 1'b1, data: b64_pkg::sextet_char(grp[5:0]), bad: 1'b0};
					n      = 3'd4;
					acc_d  = '0;
					gc_d   = '0;
				end else begin
					acc_d = {2'b00, acc_q[7:0], in_data};
					gc_d  = gc_q + 2'd1;
				end
			end
			if (in_end) begin
				// A partial group is only held when no full group left in this transaction.
				if (gc_d == 2'd1) begin
					res[0] = '{vld: 1'b1, data: b64_pkg::sextet_char(acc_d[7:2]), bad: 1'b0};
					res[1] = '{vld: 1'b1, data: b64_pkg::sextet_char({acc_d[1:0], 4'b0000}),
						bad: 1'b0};
					res[2] = '{vld: 1'b1, data: b64_pkg::CH_PAD, bad: 1'b0};
					res[3] = '{vld: 1'b1, data: b64_pkg::CH_PAD, bad: 1'b0};
					n      = 3'd4;
				end else if (gc_d == 2'd2) begin
					res[0] = '{vld: 1'b1, data: b64_pkg::sextet_char(acc_d[15:10]), bad: 1'b0};
					res[1] = '{vld: 1'b1, data: b64_pkg::sextet_char(acc_d[9:4]), bad: 1'b0};
					res[2] = '{vld: 1'b1, data: b64_pkg::sextet_char({acc_d[3:0], 2'b00}),
						bad: 1'b0};
					res[3] = '{vld: 1'b1, data: b64_pkg::CH_PAD, bad: 1'b0};
					n      = 3'd4;
				end
				res[n] = '{vld: 1'b1, data: b64_pkg::CH_NL, bad: 1'b0};
				n      = n + 3'd1;
			end
		end else begin
			if (in_flag) begin
				if (cls == b64_pkg::CLS_BAD) begin
					res[0] = '{vld: 1'b0, data: 8'h00, bad: 1'b1};
					n      = 3'd1;
				end else if (cls == b64_pkg::CLS_PAD) begin
					pad_d = 1'b1;
				end else if (cls != b64_pkg::CLS_WS && !pad_q) begin
					if (gc_q == 2'd3) begin
						grp    = {acc_q, cls[5:0]};
						res[0] = '{vld: 1'b1, data: grp[23:16], bad: 1'b0};
						res[1] = '{vld: 1'b1, data: grp[15:8], bad: 1'b0};
						res[2] = '{vld: 1'b1, data: grp[7:0], bad: 1'b0};
						n      = 3'd3;
						acc_d  = '0;
						gc_d   = '0;
					end else begin
						acc_d = {acc_q[11:0], cls[5:0]};
						gc_d  = gc_q + 2'd1;
					end
				end
			end
			if (in_end) begin
				if (gc_d == 2'd2) begin
					res[n] = '{vld: 1'b1, data: acc_d[11:4], bad: 1'b0};
					n      = n + 3'd1;
				end else if (gc_d == 2'd3) begin
					res[n]        = '{vld: 1'b1, data: acc_d[17:10], bad: 1'b0};
					res[n + 3'd1] = '{vld: 1'b1, data: acc_d[9:2], bad: 1'b0};
					n             = n + 3'd2;
				end
			end
		end
		if (in_end) begin
			// An end with nothing else to report still yields one empty result.
			if (n == '0)
				n = 3'd1;
			acc_d = '0;
			gc_d  = '0;
			pad_d = 1'b0;
		end
	end

	assign q_push = accept && (n != '0);
	assign q_cmd  = '{cnt: n, last: in_end, res: res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			gc_q  <= '0;
			pad_q <= 1'b0;
		end else if (clear) begin
			acc_q <= '0;
			gc_q  <= '0;
			pad_q <= 1'b0;
		end else if (accept) begin
			acc_q <= acc_d;
			gc_q  <= gc_d;
			pad_q <= pad_d;
		end
	end

endmodule

### src/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue
// Small command queue that decouples the front end from the result stage.
// ----------------------------------------------------------------------------
module b64_queue #(
	parameter int unsigned DEPTH = b64_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  b64_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          nempty,
	output b64_pkg::cmd_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign nempty  = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && nempty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### src/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// Takes commands from the queue and plays their results out one per cycle
// while the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module b64_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nempty,
	input  b64_pkg::cmd_t q_head,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_data,
	output logic [2:0]    out_user,
	output logic          out_last
);

	b64_pkg::cmd_t                 cur_q;
	logic                          cur_vld_q;
	logic [b64_pkg::RES_IDX_W-1:0] idx_q;
	logic                          ov_q;
	logic [7:0]                    od_q;
	logic [2:0]                    ou_q;
	logic                          ol_q;
	logic                          advance, last_slot;
	b64_pkg::res_t                 slot;

	assign advance   = cur_vld_q && (!ov_q || out_ready);
	assign last_slot = (idx_q == (cur_q.cnt - 3'd1));
	assign q_pop     = q_nempty && (!cur_vld_q || (advance && last_slot));
	assign slot      = cur_q.res[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (advance && last_slot) begin
				cur_vld_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 3'd1;
			end
			if (advance)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
		if (advance) begin
			od_q <= slot.data;
			ou_q <= {slot.bad, last_slot && cur_q.last, slot.vld};
			ol_q <= last_slot;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_user  = ou_q;
	assign out_last  = ol_q;

endmodule

### src/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder and decoder with an APB direction register.
// ----------------------------------------------------------------------------
// The front end takes one input transaction per cycle whenever the command
// queue (QUEUE_DEPTH entries) has room, and the back end delivers one result
// per cycle while the receiver is ready. Encoding throughput is therefore
// set by the single result port, and the end of a stream adds up to five
// results. Results pass through the command queue, the current-command
// register and the output register. Writing the direction register aborts
// any stream in progress.
module base64_stream_codec #(
	parameter int unsigned QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // data_valid
	input  logic        s_tlast,   // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [2:0]  m_tuser,   // out_valid, stream_done, bad_char
	output logic        m_tlast    // run_last
);

	logic          direction_q;
	logic          cfg_wr;
	logic          q_full, q_push, q_pop, q_nempty;
	b64_pkg::cmd_t q_cmd, q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == 1'(b64_pkg::REG_DIRECTION));
	assign prdata = (paddr[2] == 1'(b64_pkg::REG_DIRECTION)) ? {31'b0, direction_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			direction_q <= b64_pkg::DIR_ENCODE;
		else if (cfg_wr)
			direction_q <= pwdata[0];
	end

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.direction (direction_q),
		.clear     (cfg_wr),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.in_flag   (s_tuser),
		.in_end    (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.nempty   (q_nempty),
		.head     (q_head)
	);

	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nempty  (q_nempty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

	// The end of a stream always closes the run of its transaction.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("stream_done without run_last");

	// A result without a character carries a zero byte.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
		else $error("empty result with nonzero byte");

	// Invalid characters are only flagged while decoding.
	a_bad_in_decode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> direction_q == b64_pkg::DIR_DECODE && !m_tuser[0])
		else $error("bad_char outside decode or with data");

	// The queue is never pushed while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Base64 stream codec testbench
// Drives byte and character streams into the codec in both directions and
// predicts every output transaction from the direction register and the
// stream seen so far. A short directed part covers boundary bytes, padding,
// whitespace, invalid characters and empty streams. Random streams follow
// under several patterns of sender gaps and receiver stalls, including one
// long receiver hold-off that backs up the input side.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [2:0] DIRECTION_ADDR = 3'(b64_pkg::REG_DIRECTION * 4);
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct {
		bit       vld;
		bit [7:0] data;
		bit       last;
		bit       done;
		bit       bad;
	} codec_result_t;

	class b64_scoreboard;
		logic            direction;
		bit [17:0]       acc;
		bit [1:0]        held;
		bit              pad_seen;
		codec_result_t   expected_q[$];
		int              errors;

		function new();
			direction = b64_pkg::DIR_ENCODE;
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			acc = '0;
			held = '0;
			pad_seen = 1'b0;
		endfunction

		function void set_direction(logic dir);
			direction = dir;
			clear_stream();
		endfunction

		function bit [7:0] to_b64_char(bit [5:0] s);
			string digits;
			digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
			return digits[s];
		endfunction

		// Sextet value for alphabet characters, otherwise one of the extra classes.
		function bit [6:0] char_class(bit [7:0] c);
			if (c >= "A" && c <= "Z")
				return 7'(c - "A");
			if (c >= "a" && c <= "z")
				return 7'(c - "a" + 26);
			if (c >= "0" && c <= "9")
				return 7'(c - "0" + 52);
			if (c == "+")
				return 7'd62;
			if (c == "/")
				return 7'd63;
			if (c == b64_pkg::CH_PAD)
				return b64_pkg::CLS_PAD;
			if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == b64_pkg::CH_NL)
				return b64_pkg::CLS_WS;
			return b64_pkg::CLS_BAD;
		endfunction

		function void emit(bit vld, bit [7:0] data, bit bad);
			codec_result_t r;
			r.vld = vld;
			r.data = vld ? data : 8'h00;
			r.last = 1'b0;
			r.done = 1'b0;
			r.bad = bad;
			expected_q.push_back(r);
		endfunction

		function void encode_byte(bit valid, bit [7:0] b, bit end_mark);
			bit [23:0] g;
			if (valid) begin
				if (held == 2'd2) begin
					g = {acc[15:0], b};
					emit(1'b1, to_b64_char(g[23:18]), 1'b0);
					emit(1'b1, to_b64_char(g[17:12]), 1'b0);
					emit(1'b1, to_b64_char(g[11:6]), 1'b0);
					emit(1'b1, to_b64_char(g[5:0]), 1'b0);
					acc = '0;
					held = '0;
				end else begin
					acc = {2'b00, acc[7:0], b};
					held++;
				end
			end
			if (end_mark) begin
				if (held == 2'd1) begin
					emit(1'b1, to_b64_char(acc[7:2]), 1'b0);
					emit(1'b1, to_b64_char({acc[1:0], 4'b0000}), 1'b0);
					emit(1'b1, b64_pkg::CH_PAD, 1'b0);
					emit(1'b1, b64_pkg::CH_PAD, 1'b0);
				end else if (held == 2'd2) begin
					emit(1'b1, to_b64_char(acc[15:10]), 1'b0);
					emit(1'b1, to_b64_char({acc[9:8], acc[7:4]}), 1'b0);
					emit(1'b1, to_b64_char({acc[3:0], 2'b00}), 1'b0);
					emit(1'b1, b64_pkg::CH_PAD, 1'b0);
				end
				emit(1'b1, b64_pkg::CH_NL, 1'b0);
			end
		endfunction

		function void decode_char(bit valid, bit [7:0] c, bit end_mark);
			bit [6:0]  cls;
			bit [23:0] g;
			if (valid) begin
				cls = char_class(c);
				if (cls == b64_pkg::CLS_BAD) begin
					emit(1'b0, 8'h00, 1'b1);
				end else if (cls == b64_pkg::CLS_PAD) begin
					pad_seen = 1'b1;
				end else if (cls < b64_pkg::CLS_PAD && !pad_seen) begin
					if (held == 2'd3) begin
						g = {acc, cls[5:0]};
						emit(1'b1, g[23:16], 1'b0);
						emit(1'b1, g[15:8], 1'b0);
						emit(1'b1, g[7:0], 1'b0);
						acc = '0;
						held = '0;
					end else begin
						acc = {acc[11:0], cls[5:0]};
						held++;
					end
				end
			end
			// A single leftover sextet carries no whole byte and is dropped.
			if (end_mark) begin
				if (held == 2'd2) begin
					emit(1'b1, acc[11:4], 1'b0);
				end else if (held == 2'd3) begin
					emit(1'b1, acc[17:10], 1'b0);
					emit(1'b1, acc[9:2], 1'b0);
				end
			end
		endfunction

		function void note_input(bit valid, bit [7:0] b, bit end_mark);
			int unsigned start;
			start = expected_q.size();
			if (direction == b64_pkg::DIR_DECODE)
				decode_char(valid, b, end_mark);
			else
				encode_byte(valid, b, end_mark);
			if (end_mark) begin
				if (expected_q.size() == start)
					emit(1'b0, 8'h00, 1'b0);
				expected_q[$].done = 1'b1;
				clear_stream();
			end
			if (expected_q.size() > start)
				expected_q[$].last = 1'b1;
		endfunction

		function void check_result(bit [7:0] data, bit [2:0] user, bit last);
			codec_result_t want;
			codec_result_t got;
			got.vld = user[0];
			got.data = data;
			got.last = last;
			got.done = user[1];
			got.bad = user[2];
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result vld=%0b byte=%02h last=%0b done=%0b bad=%0b",
					$time, got.vld, got.data, got.last, got.done, got.bad);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (want.vld != got.vld || want.data != got.data || want.last != got.last ||
				want.done != got.done || want.bad != got.bad) begin
				$display("%0t: mismatch expected vld=%0b byte=%02h last=%0b done=%0b bad=%0b",
					$time, want.vld, want.data, want.last, want.done, want.bad);
				$display("%0t:          actual   vld=%0b byte=%02h last=%0b done=%0b bad=%0b",
					$time, got.vld, got.data, got.last, got.done, got.bad);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // data_byte
	logic        s_tuser = 1'b0; // data_valid
	logic        s_tlast = 1'b0; // stream_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // out_byte
	logic [2:0]  m_tuser;        // out_valid, stream_done, bad_char
	logic        m_tlast;        // run_last

	b64_scoreboard sb = new();

	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;

	base64_stream_codec u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Output side: check each transaction and pick the ready level for the next cycle.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 120;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic put_item(input bit valid, input bit [7:0] b, input bit end_mark);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= valid;
		s_tdata <= b;
		s_tlast <= end_mark;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(valid, b, end_mark);
	endtask

	// Lets all expected results drain, then waits for items still in flight.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_direction(input logic dir);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DIRECTION_ADDR;
		pwdata <= {31'b0, dir};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_direction(dir);
		// Read back the register right after the write.
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, dir}) begin
			$display("%0t: direction readback expected %08h actual %08h",
				$time, {31'b0, dir}, prdata);
			sb.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic bit [7:0] random_text_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 72)
			return sb.to_b64_char(6'($urandom_range(63)));
		if (r < 82) begin
			case ($urandom_range(3))
				0: return CH_SPACE;
				1: return CH_TAB;
				2: return CH_CR;
				default: return b64_pkg::CH_NL;
			endcase
		end
		if (r < 88)
			return b64_pkg::CH_PAD;
		return 8'($urandom_range(255));
	endfunction

	// Random streams; idle items are sent on top of the counted ones.
	task automatic random_items(input logic dir, input int unsigned count);
		int unsigned sent;
		bit [7:0]    b;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				put_item(1'b0, 8'($urandom_range(255)), 1'b0);
			end else if ($urandom_range(19) == 0) begin
				put_item(1'b0, 8'($urandom_range(255)), 1'b1);
				sent++;
			end else begin
				b = (dir == b64_pkg::DIR_DECODE) ? random_text_char() :
					8'($urandom_range(255));
				put_item(1'b1, b, $urandom_range(9) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed encode: empty stream, groups of one, two and three bytes.
		write_direction(b64_pkg::DIR_ENCODE);
		put_item(1'b0, 8'h00, 1'b1);
		put_item(1'b1, 8'hFF, 1'b1);
		put_item(1'b1, 8'hFF, 1'b0);
		put_item(1'b1, 8'h00, 1'b1);
		put_item(1'b1, 8'h00, 1'b0);
		put_item(1'b1, 8'hFF, 1'b0);
		put_item(1'b1, 8'h7F, 1'b0);
		put_item(1'b0, 8'h80, 1'b1);
		// A partial group left behind is discarded by the next direction write.
		put_item(1'b1, 8'hAB, 1'b0);
		settle();

		// Directed decode: whitespace, padding, data after padding, an invalid
		// character, a lone final sextet and a three-sextet tail.
		write_direction(b64_pkg::DIR_DECODE);
		put_item(1'b1, "/", 1'b0);
		put_item(1'b1, "+", 1'b0);
		put_item(1'b1, CH_SPACE, 1'b0);
		put_item(1'b1, "9", 1'b0);
		put_item(1'b1, CH_TAB, 1'b0);
		put_item(1'b1, CH_CR, 1'b0);
		put_item(1'b1, "a", 1'b0);
		put_item(1'b1, b64_pkg::CH_NL, 1'b0);
		put_item(1'b1, "z", 1'b0);
		put_item(1'b1, "A", 1'b0);
		put_item(1'b1, b64_pkg::CH_PAD, 1'b0);
		put_item(1'b1, "Q", 1'b0);
		put_item(1'b1, 8'h2A, 1'b0);
		put_item(1'b0, 8'h00, 1'b1);
		put_item(1'b1, "Q", 1'b1);
		put_item(1'b1, "A", 1'b0);
		put_item(1'b1, "B", 1'b0);
		put_item(1'b1, "+", 1'b1);
		settle();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
				default: begin src_idle_pct = 10; snk_stall_pct = 10; end
			endcase
			for (int d = 0; d < 2; d++) begin
				write_direction(d[0] ? b64_pkg::DIR_DECODE : b64_pkg::DIR_ENCODE);
				if (p == 0 && d == 0)
					hold_req = 1'b1;
				random_items(d[0] ? b64_pkg::DIR_DECODE : b64_pkg::DIR_ENCODE, 11);
				settle();
			end
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
